// ----- rtl/pidc_pkg.sv -----
// Shared types and codes for the dual-mode PID controller.
// Used by pidc_cfg, pidc_core and pid_controller_dual_mode; no dependencies.
package pidc_pkg;

	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P         = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I         = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D         = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_CLAMP = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_CLAMP   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND       = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_FEEDFORWARD    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE      = 3'd7;

	localparam logic KIND_COMPUTE = 1'b0;
	localparam logic KIND_CLEAR   = 1'b1;

	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	typedef struct packed {
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i;
		logic signed [31:0] gain_d;
		logic [30:0]        integral_clamp;
		logic [30:0]        output_clamp;
		logic [16:0]        deadband_fraction;
		logic signed [31:0] feedforward_gain;
		logic               loop_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] integral_acc;
		logic signed [31:0] error_prev1;
		logic signed [31:0] error_prev2;
		logic signed [31:0] output_prev;
	} state_t;

	typedef struct packed {
		logic signed [31:0] measured;
		logic signed [31:0] target;
		logic               kind;
	} item_t;

endpackage

// ----- rtl/pid_controller_dual_mode.sv -----
// Top level of the dual-mode PID controller (positional or incremental PID).
// Depends on pidc_pkg, pidc_cfg and pidc_core.
//
// Input channel s_*: one transfer is one item. s_tuser is the item kind
// (compute a control step or clear the stored state); s_tdata carries the
// setpoint in bits 31:0 and the feedback sample in bits 63:32, signed Q16.16.
// Output channel m_*: one transfer per compute item, the drive value in
// m_tdata, signed Q16.16. Clear items give no transfer on m_*.
// Configuration channel cfg_*: register writes by index, always ready; write
// only while no item is in flight.
// Timing: an item is registered at the input, computed in one pass and held
// in the output register, from which its result is shown. Throughput is one
// item per cycle while the output is not stalled, set by the single pass
// through the multipliers and the state update of the input stage.
// When m_tready is low the finished result waits in the output register and
// the input register holds one more item; s_tready then drops until the
// output drains. Reset clears the valid flags, the configuration and the controller state to zero.
module pid_controller_dual_mode (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [63:0]                      s_tdata,   // target, measured
	input  logic                             s_tuser,   // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,   // drive
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pidc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);
	import pidc_pkg::*;

	cfg_t        cfg;
	state_t      state_q;
	state_t      state_next;
	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	logic [31:0] drive_w;
	logic [31:0] drive_q;
	logic        out_valid_q;

	pidc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidc_core u_core (
		.cfg        (cfg),
		.state      (state_q),
		.item       (item_s1),
		.drive      (drive_w),
		.state_next (state_next)
	);

	// clear items need no output slot
	assign advance  = valid_s1 && ((item_s1.kind == KIND_CLEAR) || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind     <= s_tuser;
			item_s1.target   <= s_tdata[31:0];
			item_s1.measured <= s_tdata[63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && (item_s1.kind == KIND_COMPUTE)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (item_s1.kind == KIND_COMPUTE)) begin
			drive_q <= drive_w;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = drive_q;

endmodule

// ----- rtl/pidc_cfg.sv -----
// Configuration register file of the dual-mode PID controller.
// Depends on pidc_pkg for the register indexes and the cfg_t struct.
module pidc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pidc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data,
	output pidc_pkg::cfg_t                   cfg
);
	import pidc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P:         cfg_q.gain_p <= cfg_data;
				REG_GAIN_I:         cfg_q.gain_i <= cfg_data;
				REG_GAIN_D:         cfg_q.gain_d <= cfg_data;
				REG_INTEGRAL_CLAMP: cfg_q.integral_clamp <= cfg_data[30:0];
				REG_OUTPUT_CLAMP:   cfg_q.output_clamp <= cfg_data[30:0];
				REG_DEADBAND:       cfg_q.deadband_fraction <= cfg_data[16:0];
				REG_FEEDFORWARD:    cfg_q.feedforward_gain <= cfg_data;
				REG_LOOP_MODE:      cfg_q.loop_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/pidc_core.sv -----
// Combinational PID step: drive value and next controller state from one item.
// Depends on pidc_pkg for cfg_t, state_t, item_t and the mode and kind codes.
module pidc_core (
	input  pidc_pkg::cfg_t   cfg,
	input  pidc_pkg::state_t state,
	input  pidc_pkg::item_t  item,
	output logic [31:0]      drive,
	output pidc_pkg::state_t state_next
);
	import pidc_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] clampsym(input logic signed [63:0] v,
			input logic [30:0] lim);
		logic signed [63:0] lim_s;
		logic signed [31:0] r;
		lim_s = signed'({33'd0, lim});
		if (v > lim_s)
			r = lim_s[31:0];
		else if (v < -lim_s)
			r = 32'(-lim_s);
		else
			r = v[31:0];
		return r;
	endfunction

	// floor of the Q16.16 product
	function automatic logic signed [47:0] fxmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p[63:16];
	endfunction

	function automatic logic signed [63:0] add_offset(input logic signed [31:0] v,
			input logic [31:0] off);
		logic signed [63:0] off_s;
		off_s = signed'({32'd0, off});
		return (v > 32'sd0) ? (64'(v) + off_s) : (64'(v) - off_s);
	endfunction

	logic signed [31:0] err;
	logic signed [31:0] diff1;
	logic signed [31:0] diff2;
	logic signed [31:0] p_operand;
	logic signed [31:0] d_operand;
	logic signed [47:0] p_term;
	logic signed [47:0] i_term;
	logic signed [47:0] d_term;
	logic signed [47:0] ff_term;
	logic [47:0]        off_prod;
	logic [31:0]        offset;
	logic signed [31:0] integ_new;
	logic signed [31:0] pos_clamped;
	logic signed [31:0] pos_drive;
	logic signed [31:0] inc_clamped;
	logic signed [31:0] inc_drive;

	assign err   = sat32(64'(item.target) - 64'(item.measured));
	assign diff1 = sat32(64'(err) - 64'(state.error_prev1));
	assign diff2 = sat32(64'(err) - (64'(state.error_prev1) <<< 1)
		+ 64'(state.error_prev2));

	assign p_operand = (cfg.loop_mode == MODE_INCREMENTAL) ? diff1 : err;
	assign d_operand = (cfg.loop_mode == MODE_INCREMENTAL) ? diff2 : diff1;

	assign p_term  = fxmul(cfg.gain_p, p_operand);
	assign i_term  = fxmul(cfg.gain_i, err);
	assign d_term  = fxmul(cfg.gain_d, d_operand);
	assign ff_term = fxmul(cfg.feedforward_gain, item.target);

	assign off_prod = 48'(cfg.deadband_fraction) * 48'(cfg.output_clamp);
	assign offset   = off_prod[47:16];

	// positional
	assign integ_new   = clampsym(64'(state.integral_acc) + 64'(i_term), cfg.integral_clamp);
	assign pos_clamped = clampsym(64'(p_term) + 64'(integ_new) + 64'(d_term),
		cfg.output_clamp);
	assign pos_drive   = sat32(add_offset(pos_clamped, offset) + 64'(ff_term));

	// incremental
	assign inc_clamped = clampsym(64'(state.output_prev) + 64'(p_term) + 64'(i_term)
		+ 64'(d_term), cfg.output_clamp);
	assign inc_drive   = sat32(add_offset(inc_clamped, offset));

	always_comb begin
		state_next = state;
		drive = pos_drive;
		if (item.kind == KIND_CLEAR) begin
			state_next = '0;
		end else if (cfg.loop_mode == MODE_INCREMENTAL) begin
			drive = inc_drive;
			state_next.error_prev2 = state.error_prev1;
			state_next.error_prev1 = err;
			state_next.output_prev = inc_drive;
		end else begin
			state_next.integral_acc = integ_new;
			state_next.error_prev1 = err;
		end
	end

endmodule
